FILE: sv/newton_cubic_root_solver_macros.svh
// assertion macros for the newton cubic root solver
// used by the top level; needs clk and rst in the including scope
`ifndef NEWTON_CUBIC_ROOT_SOLVER_MACROS_SVH
`define NEWTON_CUBIC_ROOT_SOLVER_MACROS_SVH

`ifndef SYNTHESIS
// checked property, held off while in reset
`define NCRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also checked during reset
`define NCRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NCRS_ASSERT(lbl, prop, msg)
`define NCRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/ncrs_pkg.sv
// shared types, constants and saturation helpers for the newton cubic root solver
// no dependencies
`default_nettype none

package ncrs_pkg;

  // fixed point format
  localparam int FRAC_BITS = 20;
  localparam int DIV_W     = 32 + FRAC_BITS;
  localparam int DIV_CW    = $clog2(DIV_W + 1);

  localparam logic signed [63:0] ONE_W   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

  // register indexes
  localparam logic REG_STEP_TOLERANCE  = 1'b0;
  localparam logic REG_ITERATION_LIMIT = 1'b1;

  // result status codes
  localparam logic [1:0] OUT_CONVERGED  = 2'd0;
  localparam logic [1:0] OUT_LIMIT      = 2'd1;
  localparam logic [1:0] OUT_DERIV_ZERO = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQ_SAT,
    S_CUBE,
    S_FUNC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_UPDATE,
    S_OUT
  } ncrs_state_t;

  typedef struct packed {
    logic start;
  } ncrs_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ncrs_div_stat_t;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
    else if (v < SAT_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // floor of a product by one, then clamp
  function automatic logic signed [31:0] sat_shift(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FRAC_BITS;
    return sat32(s);
  endfunction

  // sign extend a word to 64 bits
  function automatic logic signed [63:0] sext(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

`default_nettype wire

FILE: sv/ncrs_div.sv
// bit-serial restoring divider: sat32(trunc(dividend * 2^FRAC_BITS / divisor))
// uses ncrs_pkg; one quotient bit per cycle
`default_nettype none

module ncrs_div import ncrs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ncrs_div_ctl_t        ctl,
  input  wire logic signed [31:0]   dividend,
  input  wire logic signed [31:0]   divisor,
  output ncrs_div_stat_t            stat,
  output logic signed [31:0]        quotient
);

  logic              busy;
  logic              done;
  logic              neg;
  logic [DIV_W-1:0]  num;
  logic [DIV_W-1:0]  quo;
  logic [31:0]       den;
  logic [31:0]       rem;
  logic [DIV_CW-1:0] cnt;

  logic [32:0] trial;
  logic [32:0] diff;
  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic        hi_set;
  logic        pos_ovf;
  logic        neg_ovf;

  // operand magnitudes and one restoring step
  always_comb begin
    num_mag = dividend[31] ? 32'(-dividend) : 32'(dividend);
    den_mag = divisor[31] ? 32'(-divisor) : 32'(divisor);
    trial   = {rem, num[DIV_W-1]};
    diff    = trial - {1'b0, den};
  end

  // sequencing of the serial steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      neg <= dividend[31] ^ divisor[31];
      num <= {num_mag, {FRAC_BITS{1'b0}}};
      den <= den_mag;
      rem <= '0;
      quo <= '0;
      cnt <= DIV_CW'(DIV_W);
    end else if (busy) begin
      num <= {num[DIV_W-2:0], 1'b0};
      cnt <= cnt - DIV_CW'(1);
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  // signed result with saturation
  always_comb begin
    hi_set  = |quo[DIV_W-1:32];
    pos_ovf = hi_set || quo[31];
    neg_ovf = hi_set || (quo[31] && (|quo[30:0]));
    if (!neg) quotient = pos_ovf ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    else quotient = neg_ovf ? 32'sh8000_0000 : $signed(32'(-quo[31:0]));
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

FILE: sv/newton_cubic_root_solver.sv
// newton-raphson on x^3 - x - 2, signed fixed point, one word in, one word out
// each newton step: square, saturate, cube, function, divider start and wait, update,
//   then a residual pass and output load; the serial divider sets the step time
// throughput: one guess at a time; a new word is taken once the result is in the
//   output register. rst (synchronous) returns to idle, drops output valid, zeroes
//   estimate and step count and loads the register defaults (tolerance 1, limit 100)
`default_nettype none
`include "newton_cubic_root_solver_macros.svh"

module newton_cubic_root_solver import ncrs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [30:0]         cfg_data,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [31:0]  start_guess,
  // output channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       root_estimate,
  output logic [9:0]               steps_used,
  output logic signed [31:0]       residual,
  output logic [1:0]               outcome
);

  ncrs_state_t state;
  ncrs_state_t state_next;

  logic [30:0]        step_tolerance;
  logic [9:0]         iteration_limit;
  logic signed [31:0] estimate;
  logic [9:0]         step_count;
  logic signed [31:0] x2;
  logic signed [63:0] prod;
  logic signed [31:0] f;
  logic signed [31:0] d;
  logic               closing;
  logic [1:0]         status;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] x3_now;
  logic signed [31:0] f_now;
  logic signed [31:0] d_now;
  logic signed [31:0] xn;
  logic signed [33:0] err_s;
  logic [33:0]        err;
  logic               out_load;

  ncrs_div_ctl_t      div_ctl;
  ncrs_div_stat_t     div_stat;
  logic signed [31:0] div_q;

  ncrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (f),
    .divisor  (d),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_tolerance  <= 31'd1;
      iteration_limit <= 10'd100;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEP_TOLERANCE:  step_tolerance  <= cfg_data;
        REG_ITERATION_LIMIT: iteration_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands and step arithmetic
  always_comb begin
    mul_a  = (state == S_CUBE) ? x2 : estimate;
    mul_b  = estimate;
    x3_now = sat_shift(prod);
    f_now  = sat32(sext(x3_now) - sext(estimate) - (ONE_W <<< 1));
    d_now  = sat32(sext(x2) + (sext(x2) <<< 1) - ONE_W);
    xn     = sat32(sext(estimate) - sext(div_q));
    err_s  = {xn[31], xn[31], xn} - {estimate[31], estimate[31], estimate};
    err    = err_s[33] ? 34'(-err_s) : 34'(err_s);
  end

  // sequencer
  always_comb begin
    state_next    = state;
    div_ctl.start = 1'b0;
    out_load      = 1'b0;
    in_stall      = (state != S_IDLE) || rst;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_SQ;
      S_SQ:       state_next = S_SQ_SAT;
      S_SQ_SAT:   state_next = S_CUBE;
      S_CUBE:     state_next = S_FUNC;
      S_FUNC: begin
        if (closing || d_now == 32'sd0) state_next = S_OUT;
        else state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_ctl.start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (div_stat.done) state_next = S_UPDATE;
      S_UPDATE: begin
        if (step_count >= iteration_limit || err <= {3'b000, step_tolerance}) begin
          state_next = S_SQ;
        end else begin
          state_next = S_SQ;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      estimate   <= '0;
      step_count <= '0;
      closing    <= 1'b0;
      status     <= OUT_CONVERGED;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            estimate   <= start_guess;
            step_count <= '0;
            closing    <= 1'b0;
          end
        end
        S_FUNC: begin
          if (!closing) begin
            step_count <= step_count + 10'd1;
            if (d_now == 32'sd0) status <= OUT_DERIV_ZERO;
          end
        end
        S_UPDATE: begin
          estimate <= xn;
          if (step_count >= iteration_limit) begin
            status  <= OUT_LIMIT;
            closing <= 1'b1;
          end else if (err <= {3'b000, step_tolerance}) begin
            status  <= OUT_CONVERGED;
            closing <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (state == S_SQ || state == S_CUBE) prod <= mul_a * mul_b;
    if (state == S_SQ_SAT) x2 <= sat_shift(prod);
    if (state == S_FUNC) begin
      f <= f_now;
      d <= d_now;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      root_estimate <= estimate;
      steps_used    <= step_count;
      residual      <= f;
      outcome       <= status;
    end
  end

  // checks
  `NCRS_ASSERT(a_div_idle_when_ready, !in_stall |-> !div_stat.busy, "divider busy while ready")
  `NCRS_ASSERT(a_div_done_in_wait, div_stat.done |-> state == S_DIV_WAIT, "divider done outside wait")
  `NCRS_ASSERT(a_out_from_seq, $rose(out_valid) |-> $past(state == S_OUT), "result loaded out of order")
  `NCRS_ASSERT(a_steps_bounded, out_valid |-> (steps_used != 10'd0 && (steps_used <= iteration_limit || steps_used == 10'd1)), "step count out of range")

endmodule

`default_nettype wire
